// ===== rtl/core/dhmc_pkg.sv =====
package dhmc_pkg;

  // request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_MIN_HEIGHT       = 3'd0;
  localparam logic [2:0] REG_MAX_HEIGHT       = 3'd1;
  localparam logic [2:0] REG_ARRIVE_TOLERANCE = 3'd2;
  localparam logic [2:0] REG_STALL_TOLERANCE  = 3'd3;
  localparam logic [2:0] REG_MOVE_TIMEOUT     = 3'd4;
  localparam logic [2:0] REG_STALL_TIMEOUT    = 3'd5;
  localparam logic [2:0] REG_COMMAND_INTERVAL = 3'd6;
  localparam logic [2:0] REG_COMMAND_REPEAT   = 3'd7;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    FIN_NONE    = 3'd0,
    FIN_REACHED = 3'd1,
    FIN_STOPPED = 3'd2,
    FIN_TIMEOUT = 3'd3,
    FIN_STALLED = 3'd4
  } fin_t;

  typedef struct packed {
    logic [11:0] min_height;
    logic [11:0] max_height;
    logic [7:0]  arrive_tolerance;
    logic [7:0]  stall_tolerance;
    logic [31:0] move_timeout;
    logic [31:0] stall_timeout;
    logic [31:0] command_interval;
    logic [7:0]  command_repeat;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic        height_valid;
    logic [11:0] measured_height;
    logic [11:0] goal_height;
    logic        force_refill;
    logic        queue_empty;
    logic        queue_full;
  } item_t;

  typedef struct packed {
    logic start_accepted;
    dir_t move_direction;
    logic clear_queue;
    logic issue_command;
    logic command_up;
    fin_t finish_code;
  } result_t;

  function automatic logic [11:0] abs_diff12(logic [11:0] a, logic [11:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== rtl/core/dhmc_cfg_regs.sv =====
module dhmc_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output dhmc_pkg::cfg_t     cfg
);
  import dhmc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MIN_HEIGHT:       cfg_nxt.min_height       = cfg_data[11:0];
        REG_MAX_HEIGHT:       cfg_nxt.max_height       = cfg_data[11:0];
        REG_ARRIVE_TOLERANCE: cfg_nxt.arrive_tolerance = cfg_data[7:0];
        REG_STALL_TOLERANCE:  cfg_nxt.stall_tolerance  = cfg_data[7:0];
        REG_MOVE_TIMEOUT:     cfg_nxt.move_timeout     = cfg_data;
        REG_STALL_TIMEOUT:    cfg_nxt.stall_timeout    = cfg_data;
        REG_COMMAND_INTERVAL: cfg_nxt.command_interval = cfg_data;
        REG_COMMAND_REPEAT:   cfg_nxt.command_repeat   = cfg_data[7:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_height       <= 12'd600;
      cfg_r.max_height       <= 12'd1300;
      cfg_r.arrive_tolerance <= 8'd5;
      cfg_r.stall_tolerance  <= 8'd3;
      cfg_r.move_timeout     <= 32'd30000;
      cfg_r.stall_timeout    <= 32'd2000;
      cfg_r.command_interval <= 32'd100;
      cfg_r.command_repeat   <= 8'd5;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/dhmc_step.sv =====
module dhmc_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  dhmc_pkg::item_t     item,
  input  dhmc_pkg::cfg_t      cfg,
  output dhmc_pkg::result_t   result
);
  import dhmc_pkg::*;

  // move state
  dir_t        dir_r, dir_nxt;
  logic [11:0] target_r, target_nxt;
  logic [31:0] start_time_r, start_time_nxt;
  logic [31:0] cmd_time_r, cmd_time_nxt;
  logic        cmd_sent_r, cmd_sent_nxt;
  logic [31:0] prog_time_r, prog_time_nxt;
  logic [11:0] prog_height_r, prog_height_nxt;
  logic        prog_known_r, prog_known_nxt;

  // shared compares
  logic [31:0] since_start, since_prog, since_cmd;
  logic [11:0] goal_err, tick_err, prog_delta;
  logic        goal_in_range, timed_out, progress, stall_expired;
  dir_t        want_dir;
  logic        clr, eff_empty, eff_full, wait_cmd;

  assign since_start   = item.now_ms - start_time_r;
  assign since_prog    = item.now_ms - prog_time_r;
  assign since_cmd     = item.now_ms - cmd_time_r;
  assign goal_err      = abs_diff12(item.measured_height, item.goal_height);
  assign tick_err      = abs_diff12(target_r, item.measured_height);
  assign prog_delta    = abs_diff12(item.measured_height, prog_height_r);
  assign goal_in_range = (item.goal_height >= cfg.min_height) &&
                         (item.goal_height <= cfg.max_height);
  assign timed_out     = since_start > cfg.move_timeout;
  assign progress      = !prog_known_r || (prog_delta >= {4'd0, cfg.stall_tolerance});
  assign stall_expired = since_prog > cfg.stall_timeout;
  assign want_dir      = (target_r > item.measured_height) ? DIR_UP : DIR_DOWN;

  // per-request decision
  always_comb begin
    dir_nxt         = dir_r;
    target_nxt      = target_r;
    start_time_nxt  = start_time_r;
    cmd_time_nxt    = cmd_time_r;
    cmd_sent_nxt    = cmd_sent_r;
    prog_time_nxt   = prog_time_r;
    prog_height_nxt = prog_height_r;
    prog_known_nxt  = prog_known_r;
    result          = '{start_accepted: 1'b0, move_direction: DIR_IDLE,
                        clear_queue: 1'b0, issue_command: 1'b0,
                        command_up: 1'b0, finish_code: FIN_NONE};
    clr       = 1'b0;
    eff_empty = 1'b0;
    eff_full  = 1'b0;
    wait_cmd  = 1'b0;

    case (item.req_type)
      REQ_START: begin
        if (item.height_valid && goal_in_range) begin
          result.start_accepted = 1'b1;
          clr = 1'b1;
          if (goal_err <= {4'd0, cfg.arrive_tolerance}) begin
            result.finish_code = FIN_REACHED;
          end else begin
            target_nxt      = item.goal_height;
            dir_nxt         = (item.measured_height < item.goal_height) ? DIR_UP : DIR_DOWN;
            start_time_nxt  = item.now_ms;
            cmd_time_nxt    = '0;
            cmd_sent_nxt    = 1'b0;
            prog_time_nxt   = item.now_ms;
            prog_height_nxt = item.measured_height;
            prog_known_nxt  = 1'b1;
          end
        end
      end
      REQ_STOP: begin
        clr = 1'b1;
        result.finish_code = FIN_STOPPED;
      end
      REQ_TICK: begin
        if (dir_r != DIR_IDLE) begin
          if (timed_out) begin
            clr = 1'b1;
            result.finish_code = FIN_TIMEOUT;
          end else if (item.height_valid) begin
            if (tick_err <= {4'd0, cfg.arrive_tolerance}) begin
              clr = 1'b1;
              result.finish_code = FIN_REACHED;
            end else if (!progress && stall_expired) begin
              clr = 1'b1;
              result.finish_code = FIN_STALLED;
            end else begin
              if (progress) begin
                prog_height_nxt = item.measured_height;
                prog_time_nxt   = item.now_ms;
                prog_known_nxt  = 1'b1;
              end
              // reversal drops queued commands and the interval history
              if (want_dir != dir_r) begin
                clr          = 1'b1;
                dir_nxt      = want_dir;
                cmd_time_nxt = '0;
                cmd_sent_nxt = 1'b0;
              end
              eff_empty = item.queue_empty || clr;
              eff_full  = item.queue_full && !clr;
              wait_cmd  = !item.force_refill && cmd_sent_nxt &&
                          (since_cmd < cfg.command_interval);
              if (eff_empty && !wait_cmd && (cfg.command_repeat != 8'd0) && !eff_full) begin
                result.issue_command = 1'b1;
                result.command_up    = (dir_nxt == DIR_UP);
                cmd_time_nxt         = item.now_ms;
                cmd_sent_nxt         = 1'b1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    // any finish returns the move state to rest
    if (result.finish_code != FIN_NONE) begin
      dir_nxt         = DIR_IDLE;
      target_nxt      = '0;
      start_time_nxt  = '0;
      cmd_time_nxt    = '0;
      cmd_sent_nxt    = 1'b0;
      prog_time_nxt   = '0;
      prog_height_nxt = '0;
      prog_known_nxt  = 1'b0;
    end

    result.clear_queue    = clr;
    result.move_direction = dir_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r         <= DIR_IDLE;
      target_r      <= '0;
      start_time_r  <= '0;
      cmd_time_r    <= '0;
      cmd_sent_r    <= 1'b0;
      prog_time_r   <= '0;
      prog_height_r <= '0;
      prog_known_r  <= 1'b0;
    end else if (fire) begin
      dir_r         <= dir_nxt;
      target_r      <= target_nxt;
      start_time_r  <= start_time_nxt;
      cmd_time_r    <= cmd_time_nxt;
      cmd_sent_r    <= cmd_sent_nxt;
      prog_time_r   <= prog_time_nxt;
      prog_height_r <= prog_height_nxt;
      prog_known_r  <= prog_known_nxt;
    end
  end

endmodule

// ===== rtl/core/desk_height_move_controller_top.sv =====
// Desk height move controller: takes one request (tick, start or stop) per clock cycle
// while in_stall is low and returns exactly one result per request. A request is
// captured in an input register, evaluated against the move state in one pass of
// compare logic, and its result is held in an output register; the move state is
// updated in the same cycle the result is written, so consecutive requests see each
// other's effects with no gap. in_stall rises only while the input register holds a
// request and the output register is full and stalled. Configuration writes take
// effect on the next cycle and should be made while idle.
module desk_height_move_controller_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_now_ms,
  input  logic        in_height_valid,
  input  logic [11:0] in_measured_height,
  input  logic [11:0] in_goal_height,
  input  logic        in_force_refill,
  input  logic        in_queue_empty,
  input  logic        in_queue_full,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_start_accepted,
  output logic [1:0]  out_move_direction,
  output logic        out_clear_queue,
  output logic        out_issue_command,
  output logic        out_command_up,
  output logic [2:0]  out_finish_code
);
  import dhmc_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    in_vld_r, in_vld_nxt;
  result_t res;
  result_t res_r;
  logic    out_vld_r, out_vld_nxt;
  logic    out_free, fire, in_take;

  // handshake control
  assign out_free = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign in_vld_nxt  = in_take || (in_vld_r && !fire);
  assign out_vld_nxt = fire || (out_vld_r && out_stall);

  dhmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dhmc_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .cfg    (cfg),
    .result (res)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.req_type        <= in_req_type;
      item_r.now_ms          <= in_now_ms;
      item_r.height_valid    <= in_height_valid;
      item_r.measured_height <= in_measured_height;
      item_r.goal_height     <= in_goal_height;
      item_r.force_refill    <= in_force_refill;
      item_r.queue_empty     <= in_queue_empty;
      item_r.queue_full      <= in_queue_full;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_start_accepted = res_r.start_accepted;
  assign out_move_direction = res_r.move_direction;
  assign out_clear_queue    = res_r.clear_queue;
  assign out_issue_command  = res_r.issue_command;
  assign out_command_up     = res_r.command_up;
  assign out_finish_code    = res_r.finish_code;

  // a finished move reports idle and drops the queue
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_finish_code != FIN_NONE) |->
      (out_clear_queue && out_move_direction == DIR_IDLE))
    else $error("finish without idle and queue clear");

  // commands are issued only during a move, in its direction
  a_issue_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_issue_command) |->
      (out_finish_code == FIN_NONE &&
       out_command_up == (out_move_direction == DIR_UP) &&
       out_move_direction != DIR_IDLE))
    else $error("command issued outside a move");

  // up flag only accompanies an issued command
  a_up_needs_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_command_up) |-> out_issue_command)
    else $error("command_up without issue");

  // a stalled result stays valid and unchanged until it is taken
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(res_r)))
    else $error("stalled result changed");

endmodule

// ===== tb/desk_height_move_controller_top_tb.sv =====
module desk_height_move_controller_top_tb;
  import dhmc_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int HOLD_LEN   = 300;
  localparam int RUN_LIMIT  = 1_000_000;
  localparam cfg_t CFG_RESET = {12'd600, 12'd1300, 8'd5, 8'd3, 32'd30000, 32'd2000,
                                32'd100, 8'd5};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = REQ_TICK;
  logic [31:0] in_now_ms = '0;
  logic        in_height_valid = 1'b0;
  logic [11:0] in_measured_height = '0;
  logic [11:0] in_goal_height = '0;
  logic        in_force_refill = 1'b0;
  logic        in_queue_empty = 1'b0;
  logic        in_queue_full = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_start_accepted;
  logic [1:0]  out_move_direction;
  logic        out_clear_queue;
  logic        out_issue_command;
  logic        out_command_up;
  logic [2:0]  out_finish_code;

  desk_height_move_controller_top dut (.*);

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // requests waiting to be driven, and results the controller owes us
  item_t   request_q[$];
  result_t expected_outcomes[$];

  // handshake pacing
  logic req_taken = 1'b0;
  logic idle_en = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt = 0;
  int   tx_gap = 0;
  int   rx_gap = 0;

  // bookkeeping
  int n_planned = 0;
  int n_taken = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_issued = 0;
  int n_starts_ok = 0;
  int n_settings = 1;
  int fin_tally[8];

  // controller state as we expect it
  cfg_t        desk_cfg;
  dir_t        mv_dir;
  logic [11:0] mv_target;
  logic [31:0] mv_start;
  logic [31:0] mv_cmd_time;
  logic        mv_cmd_sent;
  logic [31:0] mv_prog_time;
  logic [11:0] mv_prog_height;
  logic        mv_prog_known;

  function automatic logic [11:0] height_gap(logic [11:0] a, logic [11:0] b);
    if (a >= b) return a - b;
    return b - a;
  endfunction

  function automatic void clear_move();
    mv_dir         = DIR_IDLE;
    mv_target      = '0;
    mv_start       = '0;
    mv_cmd_time    = '0;
    mv_cmd_sent    = 1'b0;
    mv_prog_time   = '0;
    mv_prog_height = '0;
    mv_prog_known  = 1'b0;
  endfunction

  // expected result of one request, updating the move state
  task automatic predict_move(input item_t rq, output result_t res);
    logic [31:0] elapsed;
    dir_t        nxt;
    logic        stuck;
    logic        eff_empty;
    logic        eff_full;
    logic        hold_off;
    res = '0;
    case (rq.req_type)
      REQ_START: begin
        if (rq.height_valid && rq.goal_height >= desk_cfg.min_height &&
            rq.goal_height <= desk_cfg.max_height) begin
          res.start_accepted = 1'b1;
          res.clear_queue    = 1'b1;
          if (height_gap(rq.measured_height, rq.goal_height) <= desk_cfg.arrive_tolerance) begin
            clear_move();
            res.finish_code = FIN_REACHED;
          end else begin
            mv_target      = rq.goal_height;
            mv_dir         = (rq.measured_height < rq.goal_height) ? DIR_UP : DIR_DOWN;
            mv_start       = rq.now_ms;
            mv_cmd_time    = '0;
            mv_cmd_sent    = 1'b0;
            mv_prog_time   = rq.now_ms;
            mv_prog_height = rq.measured_height;
            mv_prog_known  = 1'b1;
          end
        end
      end
      REQ_STOP: begin
        clear_move();
        res.clear_queue = 1'b1;
        res.finish_code = FIN_STOPPED;
      end
      REQ_TICK: begin
        if (mv_dir != DIR_IDLE) begin
          elapsed = rq.now_ms - mv_start;
          if (elapsed > desk_cfg.move_timeout) begin
            clear_move();
            res.clear_queue = 1'b1;
            res.finish_code = FIN_TIMEOUT;
          end else if (rq.height_valid) begin
            if (height_gap(mv_target, rq.measured_height) <= desk_cfg.arrive_tolerance) begin
              clear_move();
              res.clear_queue = 1'b1;
              res.finish_code = FIN_REACHED;
            end else begin
              // progress tracking
              stuck = 1'b0;
              if (!mv_prog_known ||
                  height_gap(rq.measured_height, mv_prog_height) >=
                  desk_cfg.stall_tolerance) begin
                mv_prog_height = rq.measured_height;
                mv_prog_time   = rq.now_ms;
                mv_prog_known  = 1'b1;
              end else begin
                elapsed = rq.now_ms - mv_prog_time;
                stuck   = (elapsed > desk_cfg.stall_timeout);
              end
              if (stuck) begin
                clear_move();
                res.clear_queue = 1'b1;
                res.finish_code = FIN_STALLED;
              end else begin
                // direction and command decision
                nxt = (mv_target > rq.measured_height) ? DIR_UP : DIR_DOWN;
                if (nxt != mv_dir) begin
                  res.clear_queue = 1'b1;
                  mv_dir          = nxt;
                  mv_cmd_time     = '0;
                  mv_cmd_sent     = 1'b0;
                end
                eff_empty = rq.queue_empty || res.clear_queue;
                eff_full  = rq.queue_full && !res.clear_queue;
                elapsed   = rq.now_ms - mv_cmd_time;
                hold_off  = !rq.force_refill && mv_cmd_sent &&
                            (elapsed < desk_cfg.command_interval);
                if (eff_empty && !hold_off && desk_cfg.command_repeat != 0 && !eff_full) begin
                  res.issue_command = 1'b1;
                  res.command_up    = (mv_dir == DIR_UP);
                  mv_cmd_time       = rq.now_ms;
                  mv_cmd_sent       = 1'b1;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    res.move_direction = mv_dir;
  endtask

  task automatic flag_error(input string msg);
    $display("mismatch: %s", msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d %s got %0d expected %0d", n_results, name, got, want));
  endtask

  // driver: next request at the falling edge once the current one is taken
  always @(negedge clk) begin : driver
    item_t rq;
    if (!in_valid || req_taken) begin
      if (tx_gap != 0) begin
        in_valid <= 1'b0;
        tx_gap   <= tx_gap - 1;
      end else if (idle_en && hold_cnt == 0 && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        tx_gap   <= $urandom_range(0, 16);
      end else if (request_q.size() != 0) begin
        rq = request_q.pop_front();
        in_req_type        <= rq.req_type;
        in_now_ms          <= rq.now_ms;
        in_height_valid    <= rq.height_valid;
        in_measured_height <= rq.measured_height;
        in_goal_height     <= rq.goal_height;
        in_force_refill    <= rq.force_refill;
        in_queue_empty     <= rq.queue_empty;
        in_queue_full      <= rq.queue_full;
        in_valid           <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off
  always @(negedge clk) begin : receiver
    if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_done <= 1'b1;
      hold_cnt  <= HOLD_LEN;
    end else if (rx_gap != 0) begin
      out_stall <= 1'b1;
      rx_gap    <= rx_gap - 1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      rx_gap    <= $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: check results, then predict for a newly taken request
  always @(posedge clk) begin : monitor
    item_t   rq;
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.start_accepted = out_start_accepted;
        got.move_direction = dir_t'(out_move_direction);
        got.clear_queue    = out_clear_queue;
        got.issue_command  = out_issue_command;
        got.command_up     = out_command_up;
        got.finish_code    = fin_t'(out_finish_code);
        if (expected_outcomes.size() == 0) begin
          flag_error($sformatf("result %0d (%h) with no request pending", n_results, got));
        end else begin
          want = expected_outcomes.pop_front();
          check_field("start_accepted", got.start_accepted, want.start_accepted);
          check_field("move_direction", got.move_direction, want.move_direction);
          check_field("clear_queue", got.clear_queue, want.clear_queue);
          check_field("issue_command", got.issue_command, want.issue_command);
          check_field("command_up", got.command_up, want.command_up);
          check_field("finish_code", got.finish_code, want.finish_code);
        end
        n_results++;
      end
      if (in_valid && !in_stall) begin
        rq.req_type        = in_req_type;
        rq.now_ms          = in_now_ms;
        rq.height_valid    = in_height_valid;
        rq.measured_height = in_measured_height;
        rq.goal_height     = in_goal_height;
        rq.force_refill    = in_force_refill;
        rq.queue_empty     = in_queue_empty;
        rq.queue_full      = in_queue_full;
        predict_move(rq, want);
        expected_outcomes.push_back(want);
        n_taken++;
        fin_tally[want.finish_code]++;
        if (want.issue_command) n_issued++;
        if (want.start_accepted) n_starts_ok++;
      end
    end
    req_taken <= rst_n && in_valid && !in_stall;
  end

  task automatic add_item(input logic [1:0] rt, input logic [31:0] now, input logic hv,
                          input logic [11:0] cur, input logic [11:0] goal, input logic frc,
                          input logic qe, input logic qf);
    item_t rq;
    rq.req_type        = rt;
    rq.now_ms          = now;
    rq.height_valid    = hv;
    rq.measured_height = cur;
    rq.goal_height     = goal;
    rq.force_refill    = frc;
    rq.queue_empty     = qe;
    rq.queue_full      = qf;
    request_q.push_back(rq);
    n_planned++;
  endtask

  function automatic logic [11:0] fit12(input int v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'd4095;
    return 12'(v);
  endfunction

  // target mostly inside the range, sometimes on its edges or outside
  function automatic int pick_goal();
    int roll;
    roll = $urandom_range(0, 9);
    if (desk_cfg.min_height <= desk_cfg.max_height) begin
      if (roll == 0) return int'(desk_cfg.min_height);
      if (roll == 1) return int'(desk_cfg.max_height);
      if (roll < 9) return int'($urandom_range(desk_cfg.min_height, desk_cfg.max_height));
    end
    return int'($urandom_range(0, 4095));
  endfunction

  // moves: a start, then ticks as the desk travels, with stops, restarts and noise
  task automatic gen_moves(input int count);
    int          made;
    int          ticks;
    int          roll;
    int          h;
    int          goal;
    int          step;
    logic [31:0] t;
    logic        stuck_mode;
    made = 0;
    t = $urandom;
    if ($urandom_range(0, 3) == 0) t = 32'hFFFF_FFFF - $urandom_range(0, 20000);
    while (made < count) begin
      goal = pick_goal();
      if ($urandom_range(0, 3) == 0) h = goal + int'($urandom_range(0, 12)) - 6;
      else h = int'($urandom_range(0, 4095));
      h = int'(fit12(h));
      add_item(REQ_START, t, $urandom_range(0, 15) != 0, fit12(h), fit12(goal),
               $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
      made++;
      ticks = $urandom_range(2, 30);
      stuck_mode = ($urandom_range(0, 3) == 0);
      while (ticks > 0 && made < count) begin
        // time and height advance
        roll = $urandom_range(0, 99);
        if (roll < 2) t = t + $urandom;
        else if (roll < 12) t = t + $urandom_range(0, 3000);
        else t = t + $urandom_range(0, 150);
        step = int'($urandom_range(0, 40));
        if (stuck_mode) step = int'($urandom_range(0, 4)) - 2;
        else if ($urandom_range(0, 9) == 0) step = -step;
        h = int'(fit12((h < goal) ? h + step : h - step));
        // request kind
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          add_item(REQ_STOP, t, 1'b1, fit12(h), fit12(goal), 1'b0, 1'b1, 1'b0);
          ticks = 0;
        end else if (roll < 7) begin
          goal = pick_goal();
          add_item(REQ_START, t, 1'b1, fit12(h), fit12(goal), 1'b0, 1'b1, 1'b0);
        end else if (roll < 11) begin
          add_item(2'($urandom_range(0, 3)), $urandom, $urandom_range(0, 1) == 1,
                   12'($urandom), 12'($urandom), $urandom_range(0, 1) == 1,
                   $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
        end else begin
          add_item(REQ_TICK, t, $urandom_range(0, 9) != 0, fit12(h), 12'($urandom),
                   $urandom_range(0, 3) == 0, $urandom_range(0, 9) < 7,
                   $urandom_range(0, 4) == 0);
        end
        made++;
        ticks--;
      end
    end
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_MIN_HEIGHT:       desk_cfg.min_height       = val[11:0];
      REG_MAX_HEIGHT:       desk_cfg.max_height       = val[11:0];
      REG_ARRIVE_TOLERANCE: desk_cfg.arrive_tolerance = val[7:0];
      REG_STALL_TOLERANCE:  desk_cfg.stall_tolerance  = val[7:0];
      REG_MOVE_TIMEOUT:     desk_cfg.move_timeout     = val;
      REG_STALL_TIMEOUT:    desk_cfg.stall_timeout    = val;
      REG_COMMAND_INTERVAL: desk_cfg.command_interval = val;
      REG_COMMAND_REPEAT:   desk_cfg.command_repeat   = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(input cfg_t c);
    set_reg(REG_MIN_HEIGHT, {20'd0, c.min_height});
    set_reg(REG_MAX_HEIGHT, {20'd0, c.max_height});
    set_reg(REG_ARRIVE_TOLERANCE, {24'd0, c.arrive_tolerance});
    set_reg(REG_STALL_TOLERANCE, {24'd0, c.stall_tolerance});
    set_reg(REG_MOVE_TIMEOUT, c.move_timeout);
    set_reg(REG_STALL_TIMEOUT, c.stall_timeout);
    set_reg(REG_COMMAND_INTERVAL, c.command_interval);
    set_reg(REG_COMMAND_REPEAT, {24'd0, c.command_repeat});
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  // every request answered and the pipeline drained
  task automatic wait_idle();
    while (n_taken != n_planned || expected_outcomes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // stimulus
  initial begin : stimulus
    cfg_t c;
    int   ph;
    int   k;
    desk_cfg = CFG_RESET;
    clear_move();
    for (k = 0; k < 8; k++) fin_tally[k] = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_en <= 1'b1;

    // directed requests at reset settings
    add_item(REQ_TICK, 32'd0, 1'b1, 12'd700, 12'd0, 1'b0, 1'b1, 1'b0);        // idle tick
    add_item(REQ_UNUSED, 32'd10, 1'b1, 12'd700, 12'd900, 1'b1, 1'b1, 1'b1);   // unused code
    add_item(REQ_STOP, 32'd20, 1'b0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0);         // idle stop
    add_item(REQ_START, 32'd30, 1'b0, 12'd700, 12'd900, 1'b0, 1'b1, 1'b0);    // height unknown
    add_item(REQ_START, 32'd40, 1'b1, 12'd700, 12'd599, 1'b0, 1'b1, 1'b0);    // below range
    add_item(REQ_START, 32'd50, 1'b1, 12'd700, 12'd1301, 1'b0, 1'b1, 1'b0);   // above range
    add_item(REQ_START, 32'd60, 1'b1, 12'd605, 12'd600, 1'b0, 1'b1, 1'b0);    // already there
    add_item(REQ_START, 32'd1000, 1'b1, 12'd600, 12'd1300, 1'b0, 1'b1, 1'b0); // move up
    add_item(REQ_TICK, 32'd1050, 1'b0, 12'd610, 12'd0, 1'b0, 1'b1, 1'b0);    // height unknown
    add_item(REQ_TICK, 32'd1060, 1'b1, 12'd610, 12'd0, 1'b0, 1'b1, 1'b0);    // first command
    add_item(REQ_TICK, 32'd1100, 1'b1, 12'd620, 12'd0, 1'b0, 1'b1, 1'b0);    // interval running
    add_item(REQ_TICK, 32'd1100, 1'b1, 12'd630, 12'd0, 1'b1, 1'b1, 1'b0);    // forced refill
    add_item(REQ_TICK, 32'd1300, 1'b1, 12'd640, 12'd0, 1'b0, 1'b0, 1'b1);    // queue busy
    add_item(REQ_TICK, 32'd1400, 1'b1, 12'd1310, 12'd0, 1'b0, 1'b0, 1'b1);   // overshoot, reverse
    add_item(REQ_TICK, 32'd1500, 1'b1, 12'd1296, 12'd0, 1'b0, 1'b1, 1'b0);   // reached
    add_item(REQ_START, 32'd5000, 1'b1, 12'd1200, 12'd700, 1'b0, 1'b1, 1'b0); // move down
    add_item(REQ_START, 32'd5010, 1'b1, 12'd900, 12'd1000, 1'b0, 1'b1, 1'b0); // replace move
    add_item(REQ_START, 32'd5020, 1'b1, 12'd900, 12'd4095, 1'b0, 1'b1, 1'b0); // rejected, moving
    add_item(REQ_TICK, 32'd5100, 1'b1, 12'd901, 12'd0, 1'b0, 1'b1, 1'b0);    // little progress
    add_item(REQ_TICK, 32'd7011, 1'b1, 12'd902, 12'd0, 1'b0, 1'b1, 1'b0);    // stalled
    add_item(REQ_START, 32'hFFFF_FF00, 1'b1, 12'd800, 12'd1000, 1'b0, 1'b1, 1'b0);
    add_item(REQ_TICK, 32'h0000_7500, 1'b1, 12'd810, 12'd0, 1'b0, 1'b1, 1'b0); // timeout, wrap
    add_item(REQ_START, 32'd100, 1'b1, 12'd800, 12'd900, 1'b0, 1'b1, 1'b0);
    add_item(REQ_STOP, 32'd150, 1'b1, 12'd820, 12'd0, 1'b0, 1'b1, 1'b0);     // stop while moving
    add_item(REQ_TICK, 32'hFFFF_FFFF, 1'b1, 12'hFFF, 12'hFFF, 1'b1, 1'b1, 1'b1);

    // random moves at reset settings, with the long receiver hold-off
    gen_moves(200);
    hold_req <= 1'b1;
    wait_idle();

    // wide range, zero tolerances, no timeout, no interval, max repeat
    c = CFG_RESET;
    c.min_height       = 12'd0;
    c.max_height       = 12'd4095;
    c.arrive_tolerance = 8'd0;
    c.stall_tolerance  = 8'd0;
    c.move_timeout     = 32'hFFFF_FFFF;
    c.stall_timeout    = 32'd0;
    c.command_interval = 32'd0;
    c.command_repeat   = 8'd255;
    load_cfg(c);
    gen_moves(150);
    wait_idle();

    // high range, max tolerances, zero timeout, endless interval, repeat off
    c.min_height       = 12'd2000;
    c.max_height       = 12'd4095;
    c.arrive_tolerance = 8'd255;
    c.stall_tolerance  = 8'd255;
    c.move_timeout     = 32'd0;
    c.stall_timeout    = 32'hFFFF_FFFF;
    c.command_interval = 32'hFFFF_FFFF;
    c.command_repeat   = 8'd0;
    load_cfg(c);
    gen_moves(120);
    wait_idle();

    // inverted range: every start refused
    c.min_height       = 12'd3000;
    c.max_height       = 12'd100;
    c.arrive_tolerance = 8'd5;
    c.stall_tolerance  = 8'd3;
    c.move_timeout     = 32'd1000;
    c.stall_timeout    = 32'd500;
    c.command_interval = 32'd50;
    c.command_repeat   = 8'd1;
    load_cfg(c);
    gen_moves(60);
    wait_idle();

    // random settings, one phase without idling
    for (ph = 0; ph < 4; ph++) begin
      c.min_height       = 12'($urandom_range(0, 1500));
      c.max_height       = 12'($urandom_range(1500, 4095));
      c.arrive_tolerance = 8'($urandom_range(0, 30));
      c.stall_tolerance  = 8'($urandom_range(0, 12));
      c.move_timeout     = $urandom_range(200, 20000);
      c.stall_timeout    = $urandom_range(50, 3000);
      c.command_interval = $urandom_range(0, 400);
      c.command_repeat   = 8'($urandom_range(0, 255));
      load_cfg(c);
      idle_en <= (ph != 1);
      gen_moves(130);
      wait_idle();
    end

    // back to reset settings, no idling to the end
    load_cfg(CFG_RESET);
    idle_en <= 1'b0;
    gen_moves(150);

    // drain
    k = 0;
    while ((n_taken != n_planned || expected_outcomes.size() != 0) && k < 50000) begin
      @(negedge clk);
      k++;
    end
    repeat (10) @(negedge clk);
    if (n_taken != n_planned || expected_outcomes.size() != 0)
      flag_error($sformatf("%0d requests never taken, %0d results never came",
                           n_planned - n_taken, expected_outcomes.size()));

    $display("ran %0d requests (%0d results checked) over %0d register settings, %0d errors",
             n_taken, n_results, n_settings, n_errors);
    $display("starts accepted %0d; ends: reached %0d stopped %0d timeout %0d stalled %0d; commands %0d",
             n_starts_ok, fin_tally[FIN_REACHED], fin_tally[FIN_STOPPED],
             fin_tally[FIN_TIMEOUT], fin_tally[FIN_STALLED], n_issued);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // overall time limit
  initial begin : watchdog
    #(RUN_LIMIT);
    $display("run did not complete in time");
    $display("status: fail");
    $finish;
  end

endmodule
